>>> rtl/dbrg_pkg.sv
package dbrg_pkg;

   localparam int MAX_CHANNELS_DEF   = 64;
   localparam int MAX_ROW_LENGTH_DEF = 16;

   localparam int VALUE_W = 16;
   localparam int PROD_W  = 32;
   localparam int SUM_W   = 40;
   localparam int Y_W     = 57;
   localparam int MAX_W   = 31;
   localparam int NCH_W   = 7;
   localparam int KLEN_W  = 5;
   localparam int GRP_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int BN_SHIFT  = 24;
   localparam int RND_SHIFT = 16;

   localparam logic [MAX_W-1:0] OUT_SAT = 31'h7FFF_FFFF;

   localparam logic [1:0] ACT_WEIGHT = 2'd0;
   localparam logic [1:0] ACT_SCALE  = 2'd1;
   localparam logic [1:0] ACT_OFFSET = 2'd2;
   localparam logic [1:0] ACT_DATA   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_NUM_CHANNELS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_LENGTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GROUP_ROWS   = 2'd2;

   localparam logic [NCH_W-1:0]  NUM_CHANNELS_RST = 7'd64;
   localparam logic [KLEN_W-1:0] ROW_LENGTH_RST   = 5'd10;
   localparam logic [GRP_W-1:0]  GROUP_ROWS_RST   = 16'd32;

   typedef struct packed {
      logic [1:0]                action;
      logic [5:0]                channel;
      logic [3:0]                position;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [5:0]       out_channel;
      logic [MAX_W-1:0] out_value;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic wr_weight;
      logic wr_scale;
      logic wr_offset;
      logic mul;
      logic acc;
      logic bn_mul;
      logic fold;
      logic shift;
      logic clear;
   } cell_cmd_type;

endpackage

>>> rtl/dbrg_cell.sv
module dbrg_cell #(
   parameter int MAX_ROW_LENGTH = dbrg_pkg::MAX_ROW_LENGTH_DEF,
   parameter int EC_W = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  dbrg_pkg::cell_cmd_type             cmd,
   input  logic                               sel,
   input  logic                               in_use,
   input  logic [EC_W-1:0]                    elem_idx,
   input  logic [EC_W-1:0]                    wr_pos,
   input  logic signed [dbrg_pkg::VALUE_W-1:0] value,
   input  logic [dbrg_pkg::MAX_W-1:0]         next_max,
   output logic [dbrg_pkg::MAX_W-1:0]         max_out
);
   import dbrg_pkg::*;

   logic signed [VALUE_W-1:0] w_ff [MAX_ROW_LENGTH];
   logic signed [VALUE_W-1:0] scale_ff;
   logic signed [VALUE_W-1:0] offset_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [SUM_W-1:0]   sum_ff;
   logic signed [Y_W-1:0]     y_ff;
   logic signed [Y_W-1:0]     y_in;
   logic signed [Y_W-1:0]     rnd;
   logic [Y_W-RND_SHIFT-1:0]  rq;
   logic [MAX_W-1:0]          cand;
   logic [MAX_W-1:0]          max_ff;

   assign prod_in = value * w_ff[elem_idx];
   assign y_in    = sum_ff * scale_ff + (Y_W'(offset_ff) <<< BN_SHIFT);
   assign rnd     = y_ff + (Y_W'(1) <<< (RND_SHIFT - 1));
   assign rq      = rnd[Y_W-1:RND_SHIFT];

   always_comb begin
      if (y_ff <= 0) begin
         cand = '0;
      end else if (|rq[Y_W-RND_SHIFT-1:MAX_W]) begin
         cand = OUT_SAT;
      end else begin
         cand = rq[MAX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_weight && sel) begin
         w_ff[wr_pos] <= value;
      end
      if (cmd.wr_scale && sel) begin
         scale_ff <= value;
      end
      if (cmd.wr_offset && sel) begin
         offset_ff <= value;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.bn_mul) begin
         y_ff <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         max_ff <= '0;
      end else begin
         if (cmd.fold) begin
            sum_ff <= '0;
         end else if (cmd.acc && in_use) begin
            sum_ff <= sum_ff + SUM_W'(prod_ff);
         end
         if (cmd.clear) begin
            max_ff <= '0;
         end else if (cmd.shift) begin
            max_ff <= next_max;
         end else if (cmd.fold && in_use && (cand > max_ff)) begin
            max_ff <= cand;
         end
      end
   end

   assign max_out = max_ff;

endmodule

>>> rtl/dense_bn_relu_group_max.sv
// Fused dense layer with per-channel scale and offset, ReLU and max pooling.
// Input channel (req_valid/req_ready, req_data): each beat is a weight,
// scale or offset load for one channel, or one data element of a row.
// Result channel (rsp_valid/rsp_ready, rsp_data): at the end of each group
// of rows, one beat per channel in use, in rising channel order, last set
// on the highest channel.
// Configuration (csr_we, csr_index, csr_wdata): num_channels, row_length,
// group_rows; write only while no beat is in flight.
// Flow: a load leaves the block idle and ready for the next beat. A data
// element passes through the per-channel multiplier and accumulator; at a
// row end it then goes through the scale multiply, then round and fold into
// the running maximum. At a group end, after the fold, the block drains
// N result beats through the chain of channel cells.
// req_ready stays low until the last result beat is taken, so a stalled
// receiver holds the whole block.
// Reset clears the sums, maxima and counters and restores the registers;
// the weight, scale and offset stores hold no defined value until loaded.
module dense_bn_relu_group_max #(
   parameter int MAX_CHANNELS   = dbrg_pkg::MAX_CHANNELS_DEF,
   parameter int MAX_ROW_LENGTH = dbrg_pkg::MAX_ROW_LENGTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  dbrg_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output dbrg_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [dbrg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dbrg_pkg::GRP_W-1:0]         csr_wdata
);
   import dbrg_pkg::*;

   localparam int EC_W = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
   localparam int CC_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ACC    = 3'd1;
   localparam logic [2:0] S_BN_MUL = 3'd2;
   localparam logic [2:0] S_FOLD   = 3'd3;
   localparam logic [2:0] S_DRAIN  = 3'd4;

   logic [2:0]        state_ff;
   logic [2:0]        state_in;
   logic [NCH_W-1:0]  num_channels_ff;
   logic [KLEN_W-1:0] row_length_ff;
   logic [GRP_W-1:0]  group_rows_ff;
   logic [EC_W-1:0]   elem_ff;
   logic [GRP_W-1:0]  row_ff;
   logic [CC_W-1:0]   drain_ff;
   logic              row_end_ff;
   logic              group_end_ff;
   logic [NCH_W-1:0]  n_eff;
   logic [KLEN_W-1:0] k_eff;
   logic [GRP_W-1:0]  g_eff;
   logic              req_fire;
   logic              data_fire;
   logic              rsp_fire;
   logic              row_end;
   logic              group_end;
   logic              drain_last;
   logic              pos_ok;
   cell_cmd_type      cmd;
   logic [MAX_W-1:0]  chain [MAX_CHANNELS+1];

   always_comb begin
      if (num_channels_ff == '0) begin
         n_eff = NCH_W'(1);
      end else if (int'(num_channels_ff) > MAX_CHANNELS) begin
         n_eff = NCH_W'(MAX_CHANNELS);
      end else begin
         n_eff = num_channels_ff;
      end
      if (row_length_ff == '0) begin
         k_eff = KLEN_W'(1);
      end else if (int'(row_length_ff) > MAX_ROW_LENGTH) begin
         k_eff = KLEN_W'(MAX_ROW_LENGTH);
      end else begin
         k_eff = row_length_ff;
      end
      g_eff = (group_rows_ff == '0) ? GRP_W'(1) : group_rows_ff;
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = (state_ff == S_DRAIN);
   assign req_fire   = req_valid && req_ready;
   assign data_fire  = req_fire && (req_data.action == ACT_DATA);
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign row_end    = (int'(elem_ff) + 1) >= int'(k_eff);
   assign group_end  = row_end && ((int'(row_ff) + 1) >= int'(g_eff));
   assign drain_last = (int'(drain_ff) + 1) >= int'(n_eff);
   assign pos_ok     = int'(req_data.position) < MAX_ROW_LENGTH;

   always_comb begin
      cmd           = '0;
      cmd.wr_weight = req_fire && (req_data.action == ACT_WEIGHT) && pos_ok;
      cmd.wr_scale  = req_fire && (req_data.action == ACT_SCALE);
      cmd.wr_offset = req_fire && (req_data.action == ACT_OFFSET);
      cmd.mul       = data_fire;
      cmd.acc       = (state_ff == S_ACC);
      cmd.bn_mul    = (state_ff == S_BN_MUL);
      cmd.fold      = (state_ff == S_FOLD);
      cmd.shift     = rsp_fire;
      cmd.clear     = rsp_fire && drain_last;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (data_fire) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            state_in = row_end_ff ? S_BN_MUL : S_IDLE;
         end
         S_BN_MUL: begin
            state_in = S_FOLD;
         end
         S_FOLD: begin
            state_in = group_end_ff ? S_DRAIN : S_IDLE;
         end
         S_DRAIN: begin
            if (rsp_fire && drain_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         num_channels_ff <= NUM_CHANNELS_RST;
         row_length_ff   <= ROW_LENGTH_RST;
         group_rows_ff   <= GROUP_ROWS_RST;
         elem_ff         <= '0;
         row_ff          <= '0;
         drain_ff        <= '0;
         row_end_ff      <= 1'b0;
         group_end_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               REG_NUM_CHANNELS: num_channels_ff <= csr_wdata[NCH_W-1:0];
               REG_ROW_LENGTH:   row_length_ff   <= csr_wdata[KLEN_W-1:0];
               REG_GROUP_ROWS:   group_rows_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (data_fire) begin
            row_end_ff   <= row_end;
            group_end_ff <= group_end;
            if (row_end) begin
               elem_ff <= '0;
               row_ff  <= group_end ? '0 : row_ff + GRP_W'(1);
            end else begin
               elem_ff <= elem_ff + EC_W'(1);
            end
         end
         if (state_ff == S_FOLD) begin
            drain_ff <= '0;
         end else if (rsp_fire) begin
            drain_ff <= drain_ff + CC_W'(1);
         end
      end
   end

   assign chain[MAX_CHANNELS] = '0;

   for (genvar j = 0; j < MAX_CHANNELS; j++) begin : g_cell
      dbrg_cell #(
         .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
         .EC_W          (EC_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd),
         .sel     (int'(req_data.channel) == j),
         .in_use  (j < int'(n_eff)),
         .elem_idx(elem_ff),
         .wr_pos  (EC_W'(req_data.position)),
         .value   (req_data.value),
         .next_max(chain[j+1]),
         .max_out (chain[j])
      );
   end

   assign rsp_data.out_channel = 6'(drain_ff);
   assign rsp_data.out_value   = chain[0];
   assign rsp_data.last        = drain_last;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result channels active together");

   a_drain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(drain_ff) < int'(n_eff)))
      else $error("result beat beyond channels in use");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_data.last) |=> req_ready)
      else $error("block not idle after last result beat");

   a_mid_row: assert property (@(posedge clock) disable iff (reset)
      (data_fire && !row_end) |=> !req_ready ##1 req_ready)
      else $error("mid-row element did not finish in two cycles");

endmodule
